>>> rtl/sha1bsh_pkg.sv
// shared types, constants and helper functions for the sha-1 byte stream hash
package sha1bsh_pkg;

	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned LEN_BYTES   = 8;
	localparam int unsigned ROUNDS      = 80;
	localparam int unsigned DIGEST_WORDS = 5;

	localparam logic [6:0] LAST_OFF  = 7'(BLOCK_BYTES - 1);
	localparam logic [6:0] LEN_OFF   = 7'(BLOCK_BYTES - LEN_BYTES);
	localparam logic [6:0] LAST_RND  = 7'(ROUNDS - 1);
	localparam logic [2:0] LAST_IDX  = 3'(DIGEST_WORDS - 1);
	localparam logic [7:0] PAD_MARK  = 8'h80;

	localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_0 = 32'h5A827999;
	localparam logic [31:0] K_1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_3 = 32'hCA62C1D6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		BSEL_DATA,
		BSEL_MARK,
		BSEL_ZERO,
		BSEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      insert;
		byte_sel_t bsel;
		logic      count_en;
		logic      load_work;
		logic      round_en;
		logic [6:0] rnd;
		logic      add_chain;
		logic      capture;
	} cmd_t;

	typedef struct packed {
		logic [6:0] offset;
		logic       out_busy;
	} sts_t;

	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20) begin
			k = K_0;
		end else if (rnd < 7'd40) begin
			k = K_1;
		end else if (rnd < 7'd60) begin
			k = K_2;
		end else begin
			k = K_3;
		end
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (rnd >= 7'd40 && rnd < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage

>>> rtl/sha1bsh_ctrl.sv
// controller state machine: byte intake, padding sequence, round count, digest hand-off
module sha1bsh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                has_byte,
	input  logic                end_of_message,
	output logic                in_ready,
	input  sha1bsh_pkg::sts_t   sts,
	output sha1bsh_pkg::cmd_t   cmd
);
	import sha1bsh_pkg::*;

	state_t     state_q, state_d;
	logic [6:0] rnd_q, rnd_d;
	logic       end_q, end_d;
	logic       mark_q, mark_d;
	logic       len_ok_q, len_ok_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rnd_q    <= '0;
			end_q    <= 1'b0;
			mark_q   <= 1'b0;
			len_ok_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rnd_q    <= rnd_d;
			end_q    <= end_d;
			mark_q   <= mark_d;
			len_ok_q <= len_ok_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rnd_d    = rnd_q;
		end_d    = end_q;
		mark_d   = mark_q;
		len_ok_d = len_ok_q;
		cmd      = '0;
		cmd.bsel = BSEL_DATA;
		cmd.rnd  = rnd_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (has_byte) begin
						cmd.insert   = 1'b1;
						cmd.bsel     = BSEL_DATA;
						cmd.count_en = 1'b1;
					end
					if (has_byte && sts.offset == LAST_OFF) begin
						state_d = ST_LOAD;
						end_d   = end_of_message;
					end else if (end_of_message) begin
						state_d = ST_PAD;
						end_d   = 1'b1;
					end
				end
			end
			ST_LOAD: begin
				cmd.load_work = 1'b1;
				rnd_d         = '0;
				state_d       = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				if (rnd_q == LAST_RND) begin
					state_d = ST_ADD;
				end else begin
					rnd_d = rnd_q + 7'd1;
				end
			end
			ST_ADD: begin
				cmd.add_chain = 1'b1;
				if (!end_q) begin
					state_d = ST_IDLE;
				end else if (mark_q && len_ok_q) begin
					state_d = ST_DONE;
				end else begin
					if (mark_q) begin
						len_ok_d = 1'b1;
					end
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				cmd.insert = 1'b1;
				if (!mark_q) begin
					cmd.bsel = BSEL_MARK;
					mark_d   = 1'b1;
					len_ok_d = (sts.offset < LEN_OFF);
				end else if (!len_ok_q || sts.offset < LEN_OFF) begin
					cmd.bsel = BSEL_ZERO;
				end else begin
					cmd.bsel = BSEL_LEN;
				end
				if (sts.offset == LAST_OFF) begin
					state_d = ST_LOAD;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.capture = 1'b1;
					end_d       = 1'b0;
					mark_d      = 1'b0;
					len_ok_d    = 1'b0;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/sha1bsh_dp.sv
// datapath: message shift line, bit count, round unit, chaining words, digest output register
module sha1bsh_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  sha1bsh_pkg::cmd_t   cmd,
	output sha1bsh_pkg::sts_t   sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         digest_word,
	output logic [2:0]          word_index,
	output logic                last_word,
	output logic                length_overflow
);
	import sha1bsh_pkg::*;

	logic [511:0] msg_q;
	logic [6:0]   off_q;
	logic [63:0]  cnt_q;
	logic         ovf_q;
	logic [31:0]  h_q [DIGEST_WORDS];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [159:0] dig_q;
	logic [2:0]   idx_q;
	logic         busy_q;
	logic         dovf_q;

	logic [7:0]   ins_byte;
	logic [7:0]   len_byte;
	logic [64:0]  cnt_sum;
	logic [31:0]  w_cur;
	logic [31:0]  w_next;
	logic [31:0]  t_sum;

	assign len_byte = cnt_q[{~off_q[2:0], 3'b000} +: 8];
	assign cnt_sum  = {1'b0, cnt_q} + 65'd8;
	assign w_cur    = msg_q[511:480];
	assign w_next   = {w_cur ^ msg_q[447:416] ^ msg_q[255:224] ^ msg_q[95:64]} << 1
		| {31'd0, w_cur[31] ^ msg_q[447] ^ msg_q[255] ^ msg_q[95]};
	assign t_sum    = {a_q[26:0], a_q[31:27]} + round_f(cmd.rnd, b_q, c_q, d_q) + e_q
		+ round_k(cmd.rnd) + w_cur;

	always_comb begin
		case (cmd.bsel)
			BSEL_DATA: ins_byte = data_byte;
			BSEL_MARK: ins_byte = PAD_MARK;
			BSEL_ZERO: ins_byte = 8'h00;
			BSEL_LEN:  ins_byte = len_byte;
			default:   ins_byte = 8'h00;
		endcase
	end

	// message shift line and working variables
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			msg_q <= {msg_q[503:0], ins_byte};
		end else if (cmd.round_en) begin
			msg_q <= {msg_q[479:0], w_next};
		end
		if (cmd.load_work) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round_en) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// offset, count, chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else begin
			if (cmd.insert) begin
				off_q <= off_q + 7'd1;
			end else if (cmd.add_chain || cmd.capture) begin
				off_q <= '0;
			end
			if (cmd.capture) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.count_en) begin
				cnt_q <= cnt_sum[63:0];
				if (cnt_sum[64]) begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.capture) begin
				for (int i = 0; i < DIGEST_WORDS; i++) begin
					h_q[i] <= H_INIT[i];
				end
			end else if (cmd.add_chain) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
		end
	end

	// digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (cmd.capture) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && out_ready) begin
			if (idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dig_q  <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
			dovf_q <= ovf_q;
		end else if (busy_q && out_ready) begin
			dig_q  <= {dig_q[127:0], 32'd0};
		end
	end

	assign sts.offset      = off_q;
	assign sts.out_busy    = busy_q;
	assign out_valid       = busy_q;
	assign digest_word     = dig_q[159:128];
	assign word_index      = idx_q;
	assign last_word       = (idx_q == LAST_IDX);
	assign length_overflow = dovf_q;

endmodule

>>> rtl/sha1_byte_stream_hash.sv
// top level of the sha-1 byte stream hash: controller and datapath
// Takes at most one message byte per accepted item (when has_byte is set) and
// returns the 160-bit SHA-1 digest as five 32-bit words, H0 first, after an item
// with end_of_message set. A byte that completes a 64-byte block starts a
// compression (load, 80 rounds, chain add): the single round unit does one round
// per cycle, and no input is taken until the compression ends. An end item adds
// padding bytes up to the block boundary, one or two compressions, and the move of
// the digest into the output register. The five digest words leave that register
// one per cycle as out_ready allows, while bytes of the next message are already
// being taken; the next digest waits, with no input taken, until the previous one
// has fully left. length_overflow is set on all five words when the 64-bit bit
// count wrapped during the message.
module sha1_byte_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	output logic        length_overflow
);
	import sha1bsh_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sha1bsh_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.in_ready       (in_ready),
		.sts            (sts),
		.cmd            (cmd)
	);

	sha1bsh_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.data_byte       (data_byte),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.digest_word     (digest_word),
		.word_index      (word_index),
		.last_word       (last_word),
		.length_overflow (length_overflow)
	);

endmodule

>>> verif/sha1_byte_stream_hash_test.sv
// self-checking testbench for the sha-1 byte stream hash with its own digest predictor
`timescale 1ns / 1ps

module sha1_byte_stream_hash_test;

	localparam int unsigned LIMIT_CYCLES = 300000;
	localparam int unsigned DRAIN_CYCLES = 400;
	localparam int unsigned STALL_HOLD   = 600;
	localparam int unsigned PHASE_WORDS  = 70;
	localparam int unsigned IDLE_HEAVY   = 79;
	localparam int unsigned IDLE_BOTH    = 29;

	localparam logic [31:0] IV_0 = 32'h67452301;
	localparam logic [31:0] IV_1 = 32'hEFCDAB89;
	localparam logic [31:0] IV_2 = 32'h98BADCFE;
	localparam logic [31:0] IV_3 = 32'h10325476;
	localparam logic [31:0] IV_4 = 32'hC3D2E1F0;
	localparam logic [31:0] RC_0 = 32'h5A827999;
	localparam logic [31:0] RC_1 = 32'h6ED9EBA1;
	localparam logic [31:0] RC_2 = 32'h8F1BBCDC;
	localparam logic [31:0] RC_3 = 32'hCA62C1D6;
	localparam logic [7:0]  MARK_BYTE = 8'h80;

	localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
	localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

	typedef enum int {
		PACE_FULL,
		PACE_SRC_IDLE,
		PACE_SNK_STALL,
		PACE_BOTH
	} pace_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
		logic        length_overflow;
	} digest_item_t;

	typedef struct packed {
		logic [7:0]   data;
		logic         has;
		logic         eom;
		logic         known_ok;
		logic [159:0] known;
	} stim_row_t;

	localparam stim_row_t DIRECTED [16] = '{
		'{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},
		'{8'hFF, 1'b0, 1'b0, 1'b0, 160'h0},
		'{8'hAA, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
		'{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},
		'{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
		'{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'hFF, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'h55, 1'b0, 1'b0, 1'b0, 160'h0},
		'{8'h80, 1'b1, 1'b1, 1'b0, 160'h0},
		'{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},
		'{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},
		'{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
		'{8'h7F, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'h01, 1'b1, 1'b1, 1'b0, 160'h0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        has_byte = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic        length_overflow;

	logic [7:0]  msg_block [64];
	logic [6:0]  block_fill;
	logic [31:0] chain_h [5];
	logic [63:0] msg_bits;
	logic        bits_wrapped;

	digest_item_t digest_q [$];
	int unsigned  mismatches = 0;
	int unsigned  cycles = 0;
	int unsigned  src_idle_pct = 0;
	int unsigned  snk_stall_pct = 0;
	int unsigned  hold_requests = 0;
	int unsigned  holds_done = 0;
	int unsigned  msg_words = 0;

	sha1_byte_stream_hash u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.has_byte(has_byte),
		.end_of_message(end_of_message),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word),
		.length_overflow(length_overflow)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic void start_message();
		chain_h[0] = IV_0;
		chain_h[1] = IV_1;
		chain_h[2] = IV_2;
		chain_h[3] = IV_3;
		chain_h[4] = IV_4;
		block_fill = '0;
		msg_bits = '0;
		bits_wrapped = 1'b0;
	endfunction

	function automatic void fold_block();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		int i;
		for (i = 0; i < 16; i++) begin
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		end
		for (i = 16; i < 80; i++) begin
			w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		end
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = RC_0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = RC_1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = RC_2;
			end else begin
				f = b ^ c ^ d;
				k = RC_3;
			end
			t = rol32(a, 5) + f + e + k + w[i];
			e = d;
			d = c;
			c = rol32(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
		block_fill = '0;
	endfunction

	function automatic void pad_message();
		int p;
		int i;
		p = block_fill;
		msg_block[p] = MARK_BYTE;
		p++;
		if (p > 56) begin
			for (i = p; i < 64; i++) msg_block[i] = 8'h00;
			fold_block();
			p = 0;
		end
		for (i = p; i < 56; i++) msg_block[i] = 8'h00;
		for (i = 0; i < 8; i++) msg_block[63-i] = msg_bits[8*i +: 8];
		fold_block();
	endfunction

	// advance the predictor by one accepted word and queue any digest it yields
	function automatic void absorb_word(input logic [7:0] d, input logic h, input logic e,
			input logic known_ok, input logic [159:0] known);
		logic [64:0] sum;
		digest_item_t item;
		int k;
		if (h) begin
			sum = {1'b0, msg_bits} + 65'd8;
			if (sum[64]) bits_wrapped = 1'b1;
			msg_bits = sum[63:0];
			msg_block[block_fill[5:0]] = d;
			block_fill++;
			if (block_fill == 7'd64) fold_block();
		end
		if (e) begin
			pad_message();
			for (k = 0; k < 5; k++) begin
				item.digest_word = known_ok ? known[159-32*k -: 32] : chain_h[k];
				item.word_index = 3'(k);
				item.last_word = (k == 4);
				item.length_overflow = bits_wrapped;
				digest_q.push_back(item);
			end
			start_message();
		end
	endfunction

	task automatic send_word(input logic [7:0] d, input logic h, input logic e,
			input logic known_ok = 1'b0, input logic [159:0] known = '0);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		has_byte <= h;
		end_of_message <= e;
		do @(posedge clk); while (!in_ready);
		absorb_word(d, h, e, known_ok, known);
		msg_words++;
	endtask

	task automatic send_message(input int len);
		logic tail_byte;
		int n;
		int i;
		tail_byte = (len != 0) && ($urandom_range(1) == 1);
		n = tail_byte ? len - 1 : len;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
			send_word(8'($urandom), 1'b1, 1'b0);
		end
		send_word(8'($urandom), tail_byte, 1'b1);
	endtask

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FULL: begin
				src_idle_pct = 0;
				snk_stall_pct = 0;
			end
			PACE_SRC_IDLE: begin
				src_idle_pct = IDLE_HEAVY;
				snk_stall_pct = 0;
			end
			PACE_SNK_STALL: begin
				src_idle_pct = 0;
				snk_stall_pct = IDLE_HEAVY;
			end
			default: begin
				src_idle_pct = IDLE_BOTH;
				snk_stall_pct = IDLE_BOTH;
			end
		endcase
	endtask

	// receiver, with a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				out_ready <= 1'b0;
				repeat (STALL_HOLD) @(posedge clk);
				holds_done++;
			end
			out_ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		digest_item_t exp_item;
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				$error("digest_word: unexpected word %08h (word_index %0d)", digest_word,
					word_index);
				mismatches++;
			end else begin
				exp_item = digest_q.pop_front();
				if (digest_word !== exp_item.digest_word) begin
					$error("digest_word: expected %08h, got %08h", exp_item.digest_word,
						digest_word);
					mismatches++;
				end
				if (word_index !== exp_item.word_index) begin
					$error("word_index: expected %0d, got %0d", exp_item.word_index, word_index);
					mismatches++;
				end
				if (last_word !== exp_item.last_word) begin
					$error("last_word: expected %0b, got %0b", exp_item.last_word, last_word);
					mismatches++;
				end
				if (length_overflow !== exp_item.length_overflow) begin
					$error("length_overflow: expected %0b, got %0b", exp_item.length_overflow,
						length_overflow);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int r;
		int ph;
		int len;
		int phase_start;
		start_message();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_pace(PACE_FULL);
		for (r = 0; r < 16; r++) begin
			send_word(DIRECTED[r].data, DIRECTED[r].has, DIRECTED[r].eom, DIRECTED[r].known_ok,
				DIRECTED[r].known);
		end

		// each phase opens with a message on the padding boundary
		for (ph = 0; ph < 4; ph++) begin
			set_pace(pace_t'(ph));
			phase_start = msg_words;
			case (ph)
				0: send_message(55);
				1: send_message(56);
				2: send_message(64);
				default: send_message(63);
			endcase
			while (msg_words - phase_start < PHASE_WORDS) begin
				if ($urandom_range(11) == 0) begin
					len = $urandom_range(2) == 0 ? 57 : 65;
				end else begin
					len = $urandom_range(12);
				end
				send_message(len);
			end
		end

		// receiver holds off while short messages pile up behind the digest register
		set_pace(PACE_FULL);
		hold_requests++;
		for (r = 0; r < 8; r++) send_message($urandom_range(4));

		in_valid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/sha1bsh_pkg.sv
rtl/sha1bsh_ctrl.sv
rtl/sha1bsh_dp.sv
rtl/sha1_byte_stream_hash.sv
verif/sha1_byte_stream_hash_test.sv
